// ===== design/arpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache table with aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int AGE_W   = 4;
    localparam int CNT_W   = 5;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 4'd9;

    // item function codes
    localparam logic [1:0] FUNC_UPDATE = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_RESOLVED = 3'd0;
    localparam logic [2:0] ST_PENDING  = 3'd1;
    localparam logic [2:0] ST_UPDATED  = 3'd2;
    localparam logic [2:0] ST_ADDED    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_TICK     = 3'd5;

    typedef struct packed {
        logic [1:0]       func;
        logic [IP_W-1:0]  ip_addr;
        logic [MAC_W-1:0] mac_in;
    } t_arp_in;

    typedef struct packed {
        logic [2:0]       status;
        logic [MAC_W-1:0] mac_out;
        logic [CNT_W-1:0] removed_count;
    } t_arp_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic apply;
        logic tick_step;
        logic emit;
    } t_arpc_cmd;

    // datapath to controller
    typedef struct packed {
        logic idx_last;
        logic out_free;
    } t_arpc_sts;

endpackage

// ===== design/arpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/arpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer for the table: scan, apply, aging sweep and result hand-off.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_func,
    input  t_arpc_sts  i_sts,
    output logic       o_in_ready,
    output t_arpc_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_APPLY,
        S_TICK,
        S_EMIT
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_arpc_cmd n_cmd;
    logic      accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd.load = 1'b1;
                    if (i_in_func == FUNC_UPDATE || i_in_func == FUNC_QUERY) begin
                        n_state = S_SCAN;
                    end else if (i_in_func == FUNC_TICK) begin
                        n_state = S_TICK;
                    end
                end
            end
            S_SCAN: begin
                n_cmd.scan_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last address compare lands here
            S_DRAIN: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_cmd.apply = 1'b1;
                n_state     = S_EMIT;
            end
            S_TICK: begin
                n_cmd.tick_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = n_cmd;

endmodule

// ===== design/arpc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_dp
// Table storage, scan compare, entry update, aging and output register.
// ----------------------------------------------------------------------------
module arpc_dp
    import arpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_arpc_cmd        i_cmd,
    output t_arpc_sts        o_sts,
    input  t_arp_in          i_in_data,
    input  logic             i_cfg_valid,
    input  logic [AGE_W-1:0] i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_arp_out         o_out_data
);

    t_arp_in          r_item;
    logic [IDX_W-1:0] r_idx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic [CNT_W-1:0] r_removed;
    logic [2:0]       r_status;
    logic             r_resolved;
    logic [AGE_W-1:0] r_age_limit;
    logic             r_out_valid;
    t_arp_out         r_out;

    logic             r_valid    [ENTRIES];
    logic             r_complete [ENTRIES];
    logic [AGE_W-1:0] r_age      [ENTRIES];

    logic [IP_W-1:0]  ip_rdata;
    logic [MAC_W-1:0] mac_rdata;
    logic             ip_we;
    logic             mac_we;
    logic [IDX_W-1:0] mac_waddr;
    logic [MAC_W-1:0] mac_wdata;
    logic             mac_re;
    logic             is_update;
    logic             need_mac;
    logic             cmp_match;
    logic             add_slot;
    logic [2:0]       apply_status;

    assign is_update = (r_item.func == FUNC_UPDATE);
    assign need_mac  = (r_item.func == FUNC_QUERY) && r_hit && r_complete[r_hit_idx];
    assign cmp_match = r_cmp_vld && !r_hit && r_valid[r_cmp_idx]
                       && (ip_rdata == r_item.ip_addr);
    assign add_slot  = !r_hit && r_free;

    assign ip_we     = i_cmd.apply && add_slot;
    assign mac_we    = i_cmd.apply && (r_hit ? is_update : r_free);
    assign mac_waddr = r_hit ? r_hit_idx : r_free_idx;
    assign mac_wdata = is_update ? r_item.mac_in : '0;
    assign mac_re    = i_cmd.apply && need_mac;

    always_comb begin
        if (r_hit) begin
            if (is_update) begin
                apply_status = ST_UPDATED;
            end else begin
                apply_status = r_complete[r_hit_idx] ? ST_RESOLVED : ST_PENDING;
            end
        end else if (r_free) begin
            apply_status = is_update ? ST_ADDED : ST_PENDING;
        end else begin
            apply_status = ST_FULL;
        end
    end

    arpc_ram #(
        .WIDTH (IP_W),
        .DEPTH (ENTRIES)
    ) u_ip_ram (
        .i_clk   (i_clk),
        .i_we    (ip_we),
        .i_waddr (r_free_idx),
        .i_wdata (r_item.ip_addr),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_idx),
        .o_rdata (ip_rdata)
    );

    arpc_ram #(
        .WIDTH (MAC_W),
        .DEPTH (ENTRIES)
    ) u_mac_ram (
        .i_clk   (i_clk),
        .i_we    (mac_we),
        .i_waddr (mac_waddr),
        .i_wdata (mac_wdata),
        .i_re    (mac_re),
        .i_raddr (r_hit_idx),
        .o_rdata (mac_rdata)
    );

    // control state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_removed   <= '0;
            r_resolved  <= 1'b0;
            r_age_limit <= AGE_LIMIT_RST;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_cmp_vld <= i_cmd.scan_step;
            if (i_cfg_valid) begin
                r_age_limit <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx      <= '0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
                r_removed  <= '0;
                r_resolved <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
                // lowest free slot
                if (!r_free && !r_valid[r_idx]) begin
                    r_free <= 1'b1;
                end
            end
            if (cmp_match) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.apply) begin
                r_resolved <= need_mac;
                if (add_slot) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
            end
            if (i_cmd.tick_step) begin
                r_idx <= r_idx + 1'b1;
                if (r_valid[r_idx] && (r_age[r_idx] >= r_age_limit)) begin
                    r_valid[r_idx] <= 1'b0;
                    if (!(&r_removed)) begin
                        r_removed <= r_removed + 1'b1;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_in_data;
            r_status <= ST_TICK;
        end
        if (i_cmd.scan_step) begin
            r_cmp_idx <= r_idx;
            if (!r_free && !r_valid[r_idx]) begin
                r_free_idx <= r_idx;
            end
        end
        if (cmp_match) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (i_cmd.apply) begin
            r_status <= apply_status;
            if (r_hit && is_update) begin
                r_age[r_hit_idx]      <= '0;
                r_complete[r_hit_idx] <= 1'b1;
            end else if (add_slot) begin
                r_age[r_free_idx]      <= '0;
                r_complete[r_free_idx] <= is_update;
            end
        end
        if (i_cmd.tick_step && r_valid[r_idx] && (r_age[r_idx] < r_age_limit)) begin
            r_age[r_idx] <= r_age[r_idx] + 1'b1;
        end
        if (i_cmd.emit) begin
            r_out.status        <= r_status;
            r_out.mac_out       <= r_resolved ? mac_rdata : '0;
            r_out.removed_count <= r_removed;
        end
    end

    assign o_sts.idx_last = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken one");

    a_hit_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && r_hit && r_free) |-> (r_hit_idx != r_free_idx))
        else $error("hit slot also seen as free");

    a_removed_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick_step && !i_cmd.load) |=> (r_removed >= $past(r_removed)))
        else $error("removal count went backward");

    a_removed_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.removed_count != '0)) |-> (r_out.status == ST_TICK))
        else $error("removals reported on a non-tick result");

endmodule

// ===== design/arp_cache_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_table_top
// ARP cache table with aging: IPv4 to MAC lookup, update and aging sweep.
// ----------------------------------------------------------------------------
// One item is worked at a time. An update or query scans the table one slot
// per cycle through the single read port of the address RAM, then passes
// through a drain state for the last compare, an apply state and an emit
// state that loads the output register. An aging tick sweeps one slot per
// cycle, then loads the output register in the emit state. A result waiting
// in the output register does not hold up the next item's work, only the
// moment its own result is loaded. An item with the unused function code is
// taken and dropped with no result. The age limit register may be written
// in any cycle while the block is idle.
// ----------------------------------------------------------------------------
module arp_cache_table_top
    import arpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_arp_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_arp_out         o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [AGE_W-1:0] i_cfg_data
);

    t_arpc_cmd cmd;
    t_arpc_sts sts;

    assign o_cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_data.func),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    arpc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sim/arp_cache_table_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_table_top_test
// Self-checking bench for the ARP cache table with aging. A queue-fed driver
// offers update, query, aging-tick and unused-code requests. A shadow table
// computes the expected response for each accepted request. A monitor checks
// each response, field by field, against the oldest expectation. Phases
// change the age limit and the idle pattern on both channels.
// ----------------------------------------------------------------------------
module arp_cache_table_top_test;
    import arpc_pkg::*;

    localparam logic [1:0] FUNC_NONE   = 2'd3;  // unused selector, no response
    localparam int         POOL_SIZE   = 24;    // more addresses than slots
    localparam int         DRAIN_CYC   = ENTRIES + 24;
    localparam int         HOLD_CYC    = 400;
    localparam int         PHASE_ITEMS = 105;

    typedef enum logic [2:0] {
        IDLE_NONE,
        IDLE_TX,
        IDLE_RX,
        IDLE_BOTH,
        IDLE_HOLD
    } t_idle_mode;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_arp_in          i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_arp_out         o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [AGE_W-1:0] i_cfg_data  = '0;

    // shadow copy of the cache
    logic             tbl_valid    [ENTRIES];
    logic [IP_W-1:0]  tbl_ip       [ENTRIES];
    logic [MAC_W-1:0] tbl_mac      [ENTRIES];
    logic             tbl_complete [ENTRIES];
    logic [AGE_W-1:0] tbl_age      [ENTRIES];
    logic [AGE_W-1:0] age_limit_m  = AGE_LIMIT_RST;

    t_arp_in    arp_req_q[$];
    t_arp_out   arp_rsp_exp_q[$];
    logic [IP_W-1:0] ip_pool[POOL_SIZE];
    t_idle_mode idle_mode = IDLE_NONE;
    int         hold_cnt  = 0;
    logic       hold_done = 1'b0;
    int         err_cnt   = 0;
    int         req_accepted = 0;
    int         rsp_checked  = 0;
    int         status_seen[6];
    int         cfg_writes   = 0;

    arp_cache_table_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i]    = 1'b0;
            tbl_ip[i]       = '0;
            tbl_mac[i]      = '0;
            tbl_complete[i] = 1'b0;
            tbl_age[i]      = '0;
        end
        for (int i = 0; i < 6; i++) status_seen[i] = 0;
    end

    // applies one request to the shadow table, returns 1 when a response follows
    function automatic bit arp_cache_predict(input t_arp_in req, output t_arp_out rsp);
        int               hit;
        int               slot;
        logic [CNT_W-1:0] removed;
        rsp     = '0;
        hit     = -1;
        slot    = -1;
        removed = '0;
        if (req.func == FUNC_TICK) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (tbl_valid[i]) begin
                    if (tbl_age[i] >= age_limit_m) begin
                        tbl_valid[i] = 1'b0;
                        if (removed != 5'd31) removed = removed + 1'b1;
                    end else begin
                        tbl_age[i] = tbl_age[i] + 1'b1;
                    end
                end
            end
            rsp.status        = ST_TICK;
            rsp.removed_count = removed;
            return 1'b1;
        end
        if (req.func != FUNC_UPDATE && req.func != FUNC_QUERY) return 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_ip[i] == req.ip_addr) hit = i;
            if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        if (hit >= 0) begin
            if (req.func == FUNC_UPDATE) begin
                tbl_age[hit]      = '0;
                tbl_mac[hit]      = req.mac_in;
                tbl_complete[hit] = 1'b1;
                rsp.status        = ST_UPDATED;
            end else if (tbl_complete[hit]) begin
                rsp.status  = ST_RESOLVED;
                rsp.mac_out = tbl_mac[hit];
            end else begin
                rsp.status = ST_PENDING;
            end
        end else if (slot >= 0) begin
            // an incomplete entry carries a zero mac until a reply lands
            tbl_valid[slot]    = 1'b1;
            tbl_ip[slot]       = req.ip_addr;
            tbl_mac[slot]      = (req.func == FUNC_UPDATE) ? req.mac_in : '0;
            tbl_complete[slot] = (req.func == FUNC_UPDATE);
            tbl_age[slot]      = '0;
            rsp.status         = (req.func == FUNC_UPDATE) ? ST_ADDED : ST_PENDING;
        end else begin
            rsp.status = ST_FULL;
        end
        return 1'b1;
    endfunction

    function automatic t_arp_in mk_req(input logic [1:0] f, input logic [IP_W-1:0] ip,
                                       input logic [MAC_W-1:0] mac);
        t_arp_in r;
        r.func    = f;
        r.ip_addr = ip;
        r.mac_in  = mac;
        return r;
    endfunction

    function automatic t_arp_in rand_req();
        t_arp_in r;
        int      sel;
        sel = $urandom_range(99);
        if (sel < 35)      r.func = FUNC_UPDATE;
        else if (sel < 75) r.func = FUNC_QUERY;
        else if (sel < 95) r.func = FUNC_TICK;
        else               r.func = FUNC_NONE;
        if ($urandom_range(99) < 85) r.ip_addr = ip_pool[$urandom_range(POOL_SIZE - 1)];
        else                         r.ip_addr = $urandom;
        r.mac_in = {16'($urandom), 32'($urandom)};
        return r;
    endfunction

    function automatic bit tx_idle_now();
        case (idle_mode)
            IDLE_TX:   return $urandom_range(99) < 70;
            IDLE_BOTH: return $urandom_range(99) < 36;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit rx_stall_now();
        case (idle_mode)
            IDLE_RX:   return $urandom_range(99) < 70;
            IDLE_BOTH: return $urandom_range(99) < 36;
            IDLE_HOLD: return !hold_done;
            default:   return 1'b0;
        endcase
    endfunction

    // request driver
    always @(posedge i_clk) begin : drv_blk
        t_arp_out rsp;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                req_accepted++;
                if (arp_cache_predict(i_in_data, rsp)) arp_rsp_exp_q.push_back(rsp);
            end
            if (!i_in_valid || o_in_ready) begin
                if (arp_req_q.size() != 0 && !tx_idle_now()) begin
                    i_in_data  <= arp_req_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted once the hold phase begins
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (idle_mode == IDLE_HOLD && !hold_done) begin
            if (hold_cnt == HOLD_CYC) hold_done <= 1'b1;
            else hold_cnt <= hold_cnt + 1;
        end
    end

    // response monitor
    always @(posedge i_clk) begin : mon_blk
        t_arp_out exp_rsp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rsp_checked++;
            if (o_out_data.status <= ST_TICK) status_seen[o_out_data.status]++;
            if (arp_rsp_exp_q.size() == 0) begin
                $error("unexpected transaction: status %0d", o_out_data.status);
                err_cnt++;
            end else begin
                exp_rsp = arp_rsp_exp_q.pop_front();
                if (o_out_data.status !== exp_rsp.status) begin
                    $error("status: expected %0d, got %0d", exp_rsp.status,
                           o_out_data.status);
                    err_cnt++;
                end
                if (o_out_data.mac_out !== exp_rsp.mac_out) begin
                    $error("mac_out: expected %h, got %h", exp_rsp.mac_out,
                           o_out_data.mac_out);
                    err_cnt++;
                end
                if (o_out_data.removed_count !== exp_rsp.removed_count) begin
                    $error("removed_count: expected %0d, got %0d",
                           exp_rsp.removed_count, o_out_data.removed_count);
                    err_cnt++;
                end
            end
        end
        if (!i_rst_n) i_out_ready <= 1'b0;
        else          i_out_ready <= !rx_stall_now();
    end

    task automatic write_age_limit(input logic [AGE_W-1:0] lim);
        @(posedge i_clk);
        i_cfg_data  <= lim;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        age_limit_m = lim;
        cfg_writes++;
    endtask

    // wait until every request is out and answered, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (arp_req_q.size() != 0 || i_in_valid || arp_rsp_exp_q.size() != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_idle_mode mode, input logic [AGE_W-1:0] lim);
        write_age_limit(lim);
        @(posedge i_clk);
        idle_mode <= mode;
        @(negedge i_clk);
        for (int i = 0; i < PHASE_ITEMS; i++) arp_req_q.push_back(rand_req());
        wait_drained();
    endtask

    initial begin
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: miss, incomplete hit, resolve, add, ignored selector, tick
        arp_req_q.push_back(mk_req(FUNC_QUERY,  '0, '0));
        arp_req_q.push_back(mk_req(FUNC_QUERY,  '0, '1));
        arp_req_q.push_back(mk_req(FUNC_UPDATE, '0, '1));
        arp_req_q.push_back(mk_req(FUNC_QUERY,  '0, '0));
        arp_req_q.push_back(mk_req(FUNC_UPDATE, '1, '0));
        arp_req_q.push_back(mk_req(FUNC_QUERY,  '1, '1));
        arp_req_q.push_back(mk_req(FUNC_NONE,   '1, '1));
        arp_req_q.push_back(mk_req(FUNC_TICK,   '0, '0));
        // fill the table, then one update and one query with no room left
        for (int i = 0; i < ENTRIES - 2; i++)
            arp_req_q.push_back(mk_req(FUNC_UPDATE, 32'h0a00_0001 + i,
                                       48'h0200_0000_0000 + 48'(i * 257)));
        arp_req_q.push_back(mk_req(FUNC_UPDATE, 32'hc0a8_0101, 48'h0000_5e00_0001));
        arp_req_q.push_back(mk_req(FUNC_QUERY,  32'hc0a8_0102, '0));
        wait_drained();

        // zero limit: one tick empties a full table
        write_age_limit('0);
        @(negedge i_clk);
        arp_req_q.push_back(mk_req(FUNC_TICK, 32'h1234_5678, 48'hffff_0000_ffff));
        wait_drained();

        run_phase(IDLE_NONE, 4'd15);
        run_phase(IDLE_TX,   4'd1);
        run_phase(IDLE_RX,   4'd4);
        run_phase(IDLE_BOTH, 4'd0);
        run_phase(IDLE_HOLD, 4'd9);
        run_phase(IDLE_BOTH, 4'd15);
        run_phase(IDLE_NONE, 4'd2);

        $display("covered %0d requests, %0d responses, %0d age limit writes",
                 req_accepted, rsp_checked, cfg_writes);
        $display("responses: resolved %0d pending %0d updated %0d added %0d full %0d tick %0d",
                 status_seen[ST_RESOLVED], status_seen[ST_PENDING], status_seen[ST_UPDATED],
                 status_seen[ST_ADDED], status_seen[ST_FULL], status_seen[ST_TICK]);
        if (err_cnt == 0 && arp_rsp_exp_q.size() == 0) begin
            $display("arp_cache_table_top_test passed");
        end else begin
            $display("arp_cache_table_top_test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("arp_cache_table_top_test failed");
        $finish;
    end

endmodule
